@@ hw/rtl/pcm_ring_fifo_with_2x_upsampler_defines.svh @@
// assertion macros for the pcm ring fifo with 2x upsampler
`ifndef PCM_RING_FIFO_WITH_2X_UPSAMPLER_DEFINES_SVH
`define PCM_RING_FIFO_WITH_2X_UPSAMPLER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define PCMRF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pcmrf same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PCMRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pcmrf next-cycle check failed");

`else

`define PCMRF_ASSERT_NOW(label, clk, rstn, ante, cons)
`define PCMRF_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/pcmrf_pkg.sv @@
// shared types and constants for the pcm ring fifo with 2x upsampler
package pcmrf_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int SHIFT_W            = 4;
    localparam int WATER_W            = 12;
    localparam int CFG_DATA_W         = 12;
    localparam int CFG_ADDR_W         = 2;
    localparam int DROP_W             = 3;
    localparam int FILL_OUT_W         = 12;
    localparam int DEFAULT_RING_DEPTH = 4096;

    // commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ATTEN_SHIFT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_WATER   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_WATER  = 2'd2;

    // register reset values
    localparam logic [SHIFT_W-1:0] ATTEN_SHIFT_RST = 4'd1;
    localparam logic [WATER_W-1:0] LOW_WATER_RST   = 12'd1024;
    localparam logic [WATER_W-1:0] HIGH_WATER_RST  = 12'd3072;

    // write slots of one push: pending, midpoint, held sample twice
    localparam logic [1:0] SLOT_PEND  = 2'd0;
    localparam logic [1:0] SLOT_MID   = 2'd1;
    localparam logic [1:0] SLOT_HOLD0 = 2'd2;
    localparam logic [1:0] SLOT_HOLD1 = 2'd3;

    typedef struct packed {
        logic [1:0]         slot;
        logic [SHIFT_W-1:0] shift;
    } interp_ctrl_t;

endpackage

@@ hw/rtl/pcmrf_ram.sv @@
// sample ring storage: one write port, one read port with registered data
module pcmrf_ram #(
    parameter int DEPTH  = pcmrf_pkg::DEFAULT_RING_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = pcmrf_pkg::SAMPLE_W
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pcmrf_interp.sv @@
// linear 2x interpolation and attenuation of the sample for one write slot
module pcmrf_interp (
    input  logic signed [pcmrf_pkg::SAMPLE_W-1:0] pend_sample,
    input  logic signed [pcmrf_pkg::SAMPLE_W-1:0] new_sample,
    input  pcmrf_pkg::interp_ctrl_t               ctrl,
    output logic signed [pcmrf_pkg::SAMPLE_W-1:0] wr_sample
);

    localparam int SW = pcmrf_pkg::SAMPLE_W;

    logic signed [SW:0]   sum;
    logic signed [SW:0]   sum_adj;
    logic signed [SW:0]   half_wide;
    logic signed [SW-1:0] src;

    // halving rounds toward zero: bias negative sums by one before the shift
    assign sum       = {pend_sample[SW-1], pend_sample} + {new_sample[SW-1], new_sample};
    assign sum_adj   = sum + {{SW{1'b0}}, sum[SW]};
    assign half_wide = sum_adj >>> 1;

    always_comb begin
        case (ctrl.slot)
            pcmrf_pkg::SLOT_PEND: src = pend_sample;
            pcmrf_pkg::SLOT_MID:  src = half_wide[SW-1:0];
            default:              src = new_sample;
        endcase
    end

    assign wr_sample = src >>> ctrl.shift;

endmodule

@@ hw/rtl/pcm_ring_fifo_with_2x_upsampler.sv @@
// top level: pcm ring fifo with 2x linear upsampler on the write side
// push: accept, then n = 0, 2 or 4 ring writes, one per cycle through the single memory
// write port, then the result; pop: read issue, data capture from the registered memory
// read, then the result (an empty ring skips the read); flush and the unused command: result
// one transaction is worked at a time; the next is taken once the result is registered
// reset (aresetn low, synchronous) clears pointers, fill count, pending sample, control
// state and restores the register defaults; ring contents are not cleared
module pcm_ring_fifo_with_2x_upsampler #(
    parameter int RING_DEPTH = pcmrf_pkg::DEFAULT_RING_DEPTH
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [pcmrf_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [pcmrf_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // command channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_cmd,
    input  logic signed [pcmrf_pkg::SAMPLE_W-1:0]  s_in_sample,
    input  logic                                   s_chunk_end,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pcmrf_pkg::SAMPLE_W-1:0]  m_out_sample,
    output logic                                   m_underrun,
    output logic [pcmrf_pkg::DROP_W-1:0]           m_dropped,
    output logic [pcmrf_pkg::FILL_OUT_W-1:0]       m_fill_level,
    output logic                                   m_below_low,
    output logic                                   m_above_high
);

`include "pcm_ring_fifo_with_2x_upsampler_defines.svh"

    localparam int SW     = pcmrf_pkg::SAMPLE_W;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    // compare width covers both the fill count and the 12-bit thresholds
    localparam int CMP_W  = (PTR_W > pcmrf_pkg::WATER_W) ? PTR_W : pcmrf_pkg::WATER_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // controller states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WRITE    = 3'd1;
    localparam logic [2:0] ST_POP      = 3'd2;
    localparam logic [2:0] ST_POP_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0] state_reg, state_next;

    // configuration registers
    logic [pcmrf_pkg::SHIFT_W-1:0] atten_shift_reg;
    logic [pcmrf_pkg::WATER_W-1:0] low_water_reg;
    logic [pcmrf_pkg::WATER_W-1:0] high_water_reg;

    // ring pointers and fill count
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] fill_reg, fill_next;

    // upsampler state
    logic signed [SW-1:0] pend_sample_reg, pend_sample_next;
    logic                 pend_valid_reg, pend_valid_next;

    // latched transaction
    logic [1:0]           cmd_reg, cmd_next;
    logic signed [SW-1:0] sample_reg, sample_next;
    logic                 last_reg, last_next;
    logic [1:0]           slot_reg, slot_next;
    logic [1:0]           end_slot_reg, end_slot_next;

    // per-transaction result
    logic signed [SW-1:0]            osamp_reg, osamp_next;
    logic                            under_reg, under_next;
    logic [pcmrf_pkg::DROP_W-1:0]    drop_reg, drop_next;

    // output register
    logic                               m_valid_reg, m_valid_next;
    logic signed [SW-1:0]               m_out_sample_reg;
    logic                               m_underrun_reg;
    logic [pcmrf_pkg::DROP_W-1:0]       m_dropped_reg;
    logic [pcmrf_pkg::FILL_OUT_W-1:0]   m_fill_level_reg;
    logic                               m_below_low_reg;
    logic                               m_above_high_reg;

    // memory side
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic signed [SW-1:0] ram_wr_data;
    logic [SW-1:0]        ram_rd_data;

    pcmrf_pkg::interp_ctrl_t interp_ctrl;

    logic             s_fire;
    logic             out_free;
    logic             ring_full;
    logic             ring_empty;
    logic [CMP_W-1:0] fill_ext;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign ring_full  = (fill_reg == PTR_LAST);
    assign ring_empty = (fill_reg == '0);
    assign fill_ext   = CMP_W'(fill_reg);

    // the interpolator works on the latched sample and the pending one
    assign interp_ctrl.slot  = slot_reg;
    assign interp_ctrl.shift = atten_shift_reg;

    pcmrf_interp u_interp (
        .pend_sample (pend_sample_reg),
        .new_sample  (sample_reg),
        .ctrl        (interp_ctrl),
        .wr_sample   (ram_wr_data)
    );

    // reads happen only in the pop read state and writes only in the write state,
    // so accesses to one entry never overlap and no forwarding is needed
    assign ram_wr_en = (state_reg == ST_WRITE) && !ring_full;
    assign ram_rd_en = (state_reg == ST_POP) && !ring_empty;

    pcmrf_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (SW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // configuration writes; indexes beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atten_shift_reg <= pcmrf_pkg::ATTEN_SHIFT_RST;
            low_water_reg   <= pcmrf_pkg::LOW_WATER_RST;
            high_water_reg  <= pcmrf_pkg::HIGH_WATER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pcmrf_pkg::REG_ATTEN_SHIFT:
                    atten_shift_reg <= cfg_wdata[pcmrf_pkg::SHIFT_W-1:0];
                pcmrf_pkg::REG_LOW_WATER:
                    low_water_reg   <= cfg_wdata[pcmrf_pkg::WATER_W-1:0];
                pcmrf_pkg::REG_HIGH_WATER:
                    high_water_reg  <= cfg_wdata[pcmrf_pkg::WATER_W-1:0];
                default: ;
            endcase
        end
    end

    // controller
    always_comb begin
        state_next       = state_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        fill_next        = fill_reg;
        pend_sample_next = pend_sample_reg;
        pend_valid_next  = pend_valid_reg;
        cmd_next         = cmd_reg;
        sample_next      = sample_reg;
        last_next        = last_reg;
        slot_next        = slot_reg;
        end_slot_next    = end_slot_reg;
        osamp_next       = osamp_reg;
        under_next       = under_reg;
        drop_next        = drop_reg;
        m_valid_next     = m_valid_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next    = s_cmd;
                    sample_next = s_in_sample;
                    last_next   = s_chunk_end;
                    osamp_next  = '0;
                    under_next  = 1'b0;
                    drop_next   = '0;
                    // pending pair goes in slots 0-1, held pair in slots 2-3
                    slot_next     = pend_valid_reg ? pcmrf_pkg::SLOT_PEND
                                                   : pcmrf_pkg::SLOT_HOLD0;
                    end_slot_next = s_chunk_end ? pcmrf_pkg::SLOT_HOLD1
                                                : pcmrf_pkg::SLOT_MID;
                    unique case (s_cmd)
                        pcmrf_pkg::CMD_PUSH: begin
                            // first sample of a chunk only becomes pending
                            if (pend_valid_reg || s_chunk_end) begin
                                state_next = ST_WRITE;
                            end else begin
                                state_next = ST_DONE;
                            end
                        end
                        pcmrf_pkg::CMD_POP: begin
                            state_next = ST_POP;
                        end
                        pcmrf_pkg::CMD_FLUSH: begin
                            rd_ptr_next      = '0;
                            wr_ptr_next      = '0;
                            fill_next        = '0;
                            pend_sample_next = '0;
                            pend_valid_next  = 1'b0;
                            state_next       = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                // one ring write per cycle; a full ring drops and counts it
                if (ring_full) begin
                    drop_next = drop_reg + 1'b1;
                end else begin
                    wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    fill_next   = fill_reg + 1'b1;
                end
                if (slot_reg == end_slot_reg) begin
                    state_next = ST_DONE;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_POP: begin
                if (ring_empty) begin
                    under_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                    fill_next   = fill_reg - 1'b1;
                    state_next  = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                // memory data lands in the cycle after the read
                osamp_next = ram_rd_data;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // upsampler state moves on once the writes are done
                if (cmd_reg == pcmrf_pkg::CMD_PUSH) begin
                    if (last_reg) begin
                        pend_sample_next = '0;
                        pend_valid_next  = 1'b0;
                    end else begin
                        pend_sample_next = sample_reg;
                        pend_valid_next  = 1'b1;
                    end
                end
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            fill_reg        <= '0;
            pend_sample_reg <= '0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            fill_reg        <= fill_next;
            pend_sample_reg <= pend_sample_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        slot_reg     <= slot_next;
        end_slot_reg <= end_slot_next;
        osamp_reg    <= osamp_next;
        under_reg    <= under_next;
        drop_reg     <= drop_next;
    end

    // result register, loaded as the transaction finishes
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_out_sample_reg <= osamp_reg;
            m_underrun_reg   <= under_reg;
            m_dropped_reg    <= drop_reg;
            m_fill_level_reg <= fill_ext[pcmrf_pkg::FILL_OUT_W-1:0];
            m_below_low_reg  <= (fill_ext < CMP_W'(low_water_reg));
            m_above_high_reg <= (fill_ext >= CMP_W'(high_water_reg));
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_out_sample_reg;
    assign m_underrun   = m_underrun_reg;
    assign m_dropped    = m_dropped_reg;
    assign m_fill_level = m_fill_level_reg;
    assign m_below_low  = m_below_low_reg;
    assign m_above_high = m_above_high_reg;

    // fill count always agrees with the pointer distance
    `PCMRF_ASSERT_NOW(a_fill_matches_ptrs, aclk, aresetn, 1'b1,
        fill_reg == PTR_W'(wr_ptr_reg - rd_ptr_reg + ((wr_ptr_reg >= rd_ptr_reg) ? 0 : RING_DEPTH)))

    // a ring write never lands on the one slot kept empty
    `PCMRF_ASSERT_NOW(a_no_write_when_full, aclk, aresetn, ram_wr_en, fill_reg != PTR_LAST)

    // read and write ports are never busy in the same cycle
    `PCMRF_ASSERT_NOW(a_no_rd_wr_overlap, aclk, aresetn, ram_rd_en, !ram_wr_en)

    // an underrun result carries a zero sample
    `PCMRF_ASSERT_NOW(a_underrun_zero, aclk, aresetn, m_valid_reg && m_underrun_reg,
        m_out_sample_reg == '0)

    // a memory read is always followed by the data capture state
    `PCMRF_ASSERT_NEXT(a_read_then_capture, aclk, aresetn, ram_rd_en, state_reg == ST_POP_WAIT)

endmodule

@@ bench/tb.sv @@
// self-checking testbench for the pcm ring fifo with 2x upsampler
`timescale 1ns / 100ps

module tb;

    // package constants taken by scoped name
    localparam int SAMPLE_W           = pcmrf_pkg::SAMPLE_W;
    localparam int SHIFT_W            = pcmrf_pkg::SHIFT_W;
    localparam int WATER_W            = pcmrf_pkg::WATER_W;
    localparam int CFG_DATA_W         = pcmrf_pkg::CFG_DATA_W;
    localparam int CFG_ADDR_W         = pcmrf_pkg::CFG_ADDR_W;
    localparam int DROP_W             = pcmrf_pkg::DROP_W;
    localparam int FILL_OUT_W         = pcmrf_pkg::FILL_OUT_W;
    localparam logic [1:0] CMD_PUSH   = pcmrf_pkg::CMD_PUSH;
    localparam logic [1:0] CMD_POP    = pcmrf_pkg::CMD_POP;
    localparam logic [1:0] CMD_FLUSH  = pcmrf_pkg::CMD_FLUSH;
    localparam logic [CFG_ADDR_W-1:0] REG_ATTEN_SHIFT = pcmrf_pkg::REG_ATTEN_SHIFT;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_WATER   = pcmrf_pkg::REG_LOW_WATER;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_WATER  = pcmrf_pkg::REG_HIGH_WATER;
    localparam logic [SHIFT_W-1:0] ATTEN_SHIFT_RST = pcmrf_pkg::ATTEN_SHIFT_RST;
    localparam logic [WATER_W-1:0] LOW_WATER_RST   = pcmrf_pkg::LOW_WATER_RST;
    localparam logic [WATER_W-1:0] HIGH_WATER_RST  = pcmrf_pkg::HIGH_WATER_RST;

    localparam int DEPTH = pcmrf_pkg::DEFAULT_RING_DEPTH;
    localparam int MAX_GAP = 18;
    // the limit covers a worst-case run: idle gaps on both sides and the busy time of
    // each transaction, plus the quiet time between phases
    localparam int CYCLE_LIMIT = 200_000;
    // the command code the block treats as a status-only request
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum int {MIX_GENERAL, MIX_FILL, MIX_DRAIN} mix_t;

    // one result transaction as the block reports it
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       under;
        logic [DROP_W-1:0]          drop;
        logic [FILL_OUT_W-1:0]      fill;
        logic                       low;
        logic                       high;
    } ring_report_t;

    // one row of the directed table; typed rows carry their own expected report
    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
        logic                       typed;
        ring_report_t               rpt;
    } stim_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]         cfg_addr = '0;
    logic [CFG_DATA_W-1:0]         cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_cmd = CMD_PUSH;
    logic signed [SAMPLE_W-1:0]    s_in_sample = '0;
    logic                          s_chunk_end = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]    m_out_sample;
    logic                          m_underrun;
    logic [DROP_W-1:0]             m_dropped;
    logic [FILL_OUT_W-1:0]         m_fill_level;
    logic                          m_below_low;
    logic                          m_above_high;

    pcm_ring_fifo_with_2x_upsampler DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_in_sample  (s_in_sample),
        .s_chunk_end  (s_chunk_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_underrun   (m_underrun),
        .m_dropped    (m_dropped),
        .m_fill_level (m_fill_level),
        .m_below_low  (m_below_low),
        .m_above_high (m_above_high)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: its own ring, pointers, pending sample, registers
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0]  ring_mem [DEPTH];
    int                   rd_idx = 0;
    int                   wr_idx = 0;
    int                   held_smp = 0;
    bit                   held_ok = 1'b0;
    logic [SHIFT_W-1:0]   atten = ATTEN_SHIFT_RST;
    logic [WATER_W-1:0]   low_mark = LOW_WATER_RST;
    logic [WATER_W-1:0]   high_mark = HIGH_WATER_RST;

    ring_report_t         report_q [$];
    ring_report_t         want_rpt;
    int                   errors = 0;
    int                   sent = 0;
    int                   drop_pushes = 0;
    int                   underruns = 0;
    int                   peak_fill = 0;
    int                   cycle_cnt = 0;
    bit                   idling = 1'b1;

    function automatic int ring_count();
        return (wr_idx >= rd_idx) ? (wr_idx - rd_idx) : (DEPTH - (rd_idx - wr_idx));
    endfunction

    // arithmetic shift on a full-width signed value
    function automatic int attenuate(int v);
        return v >>> atten;
    endfunction

    // one ring write; returns 1 when the ring was full and the write is lost
    function automatic bit ring_write(int v);
        if (ring_count() >= DEPTH - 1)
            return 1'b1;
        ring_mem[wr_idx] = v[SAMPLE_W-1:0];
        wr_idx = (wr_idx + 1) % DEPTH;
        return 1'b0;
    endfunction

    // apply one command transaction and return the report it must produce
    function automatic ring_report_t advance_ring(logic [1:0] cmd,
                                                  logic signed [SAMPLE_W-1:0] smp,
                                                  logic last);
        ring_report_t r;
        int b;
        int dr;
        int h;
        int fl;
        r = '0;
        b = smp;
        dr = 0;
        case (cmd)
            CMD_PUSH: begin
                // pending sample first, then the midpoint toward the new one
                if (held_ok) begin
                    dr += ring_write(attenuate(held_smp));
                    dr += ring_write(attenuate((held_smp + b) / 2));
                end
                // chunk end holds its own sample twice and ends the chunk
                if (last) begin
                    h = attenuate(b);
                    dr += ring_write(h);
                    dr += ring_write(h);
                    held_ok = 1'b0;
                    held_smp = 0;
                end else begin
                    held_smp = b;
                    held_ok = 1'b1;
                end
            end
            CMD_POP: begin
                if (ring_count() == 0) begin
                    r.under = 1'b1;
                    underruns++;
                end else begin
                    r.smp = ring_mem[rd_idx];
                    rd_idx = (rd_idx + 1) % DEPTH;
                end
            end
            CMD_FLUSH: begin
                rd_idx = 0;
                wr_idx = 0;
                held_ok = 1'b0;
                held_smp = 0;
            end
            default: ;
        endcase
        fl = ring_count();
        if (dr != 0)
            drop_pushes++;
        if (fl > peak_fill)
            peak_fill = fl;
        r.drop = dr[DROP_W-1:0];
        r.fill = fl[FILL_OUT_W-1:0];
        r.low  = (fl < int'(low_mark));
        r.high = (fl >= int'(high_mark));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // directed table, walked once after reset with the default registers
    // ---------------------------------------------------------------
    localparam int N_DIR = 24;
    stim_row_t dir_table [N_DIR] = '{
        // pop on an empty ring right after reset
        '{CMD_POP,    16'sh0000, 1'b0, 1'b1, '{16'sh0000, 1'b1, 3'd0, 12'd0, 1'b1, 1'b0}},
        // unused command only reports status
        '{CMD_UNUSED, 16'sh1234, 1'b1, 1'b1, '{16'sh0000, 1'b0, 3'd0, 12'd0, 1'b1, 1'b0}},
        '{CMD_FLUSH,  16'sh0000, 1'b0, 1'b1, '{16'sh0000, 1'b0, 3'd0, 12'd0, 1'b1, 1'b0}},
        // first sample of a chunk only becomes pending
        '{CMD_PUSH,   16'sh7fff, 1'b0, 1'b1, '{16'sh0000, 1'b0, 3'd0, 12'd0, 1'b1, 1'b0}},
        // extremes: max then min with chunk end, four writes
        '{CMD_PUSH,   16'sh8000, 1'b1, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b1, '{16'sh0000, 1'b1, 3'd0, 12'd0, 1'b1, 1'b0}},
        '{CMD_PUSH,   16'shffff, 1'b0, 1'b0, '0},
        '{CMD_PUSH,   16'shffff, 1'b1, 1'b0, '0},
        // midpoints that truncate toward zero, not toward minus infinity
        '{CMD_PUSH,   16'sh0001, 1'b0, 1'b0, '0},
        '{CMD_PUSH,   16'shfffe, 1'b0, 1'b0, '0},
        '{CMD_PUSH,   16'shfffd, 1'b0, 1'b0, '0},
        '{CMD_PUSH,   16'sh7fff, 1'b1, 1'b0, '0},
        '{CMD_UNUSED, 16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        // flush with data in the ring
        '{CMD_FLUSH,  16'sh0000, 1'b0, 1'b1, '{16'sh0000, 1'b0, 3'd0, 12'd0, 1'b1, 1'b0}},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b1, '{16'sh0000, 1'b1, 3'd0, 12'd0, 1'b1, 1'b0}},
        // chunk end with nothing pending writes the held pair only
        '{CMD_PUSH,   16'sh0064, 1'b1, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0},
        '{CMD_POP,    16'sh0000, 1'b0, 1'b0, '0}
    };

    // idle draw for one transaction, zero more often
    function automatic int draw_gap();
        if (!idling || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // present one command transaction and wait for its acceptance; starts and ends
    // on a falling edge
    task automatic send_item(logic [1:0] cmd, logic signed [SAMPLE_W-1:0] smp,
                             logic last, logic typed, ring_report_t typed_rpt);
        int gap;
        ring_report_t r;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd       <= cmd;
        s_in_sample <= smp;
        s_chunk_end <= last;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        r = advance_ring(cmd, smp, last);
        report_q.push_back(typed ? typed_rpt : r);
        sent++;
        @(negedge aclk);
    endtask

    // random command with a mix that steers the ring fill
    task automatic send_random(mix_t mix);
        int r;
        logic [1:0] c;
        logic signed [SAMPLE_W-1:0] v;
        logic l;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  c = (r < 90) ? CMD_PUSH : CMD_POP;
            MIX_DRAIN: c = (r < 90) ? CMD_POP : CMD_PUSH;
            default:   c = (r < 55) ? CMD_PUSH : (r < 92) ? CMD_POP :
                           (r < 95) ? CMD_FLUSH : CMD_UNUSED;
        endcase
        // corner values a quarter of the time
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
                0:       v = 16'sh8000;
                1:       v = 16'sh7fff;
                2:       v = 16'shffff;
                3:       v = 16'sh0001;
                default: v = 16'sh0000;
            endcase
        end else begin
            v = SAMPLE_W'($urandom());
        end
        l = (mix == MIX_FILL) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 9) < 3);
        send_item(c, v, l, 1'b0, '0);
    endtask

    // drop valid and let every outstanding result come back, plus the block latency
    task automatic quiesce();
        s_valid <= 1'b0;
        while (report_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // write all three registers on consecutive cycles, only while idle
    task automatic set_regs(logic [SHIFT_W-1:0] shift, logic [WATER_W-1:0] lo,
                            logic [WATER_W-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_ATTEN_SHIFT;
        cfg_wdata <= CFG_DATA_W'(shift);
        @(negedge aclk);
        cfg_addr  <= REG_LOW_WATER;
        cfg_wdata <= lo;
        @(negedge aclk);
        cfg_addr  <= REG_HIGH_WATER;
        cfg_wdata <= hi;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        atten     = shift;
        low_mark  = lo;
        high_mark = hi;
    endtask

    // ---------------------------------------------------------------
    // result side: random stalls on m_ready, driven at the falling edge
    // ---------------------------------------------------------------
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // compare each accepted result with the oldest expected report
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $error("result transaction with nothing outstanding");
                errors++;
            end else begin
                want_rpt = report_q.pop_front();
                if (m_out_sample !== want_rpt.smp) begin
                    $error("out_sample expected %0d got %0d",
                           $signed(want_rpt.smp), $signed(m_out_sample));
                    errors++;
                end
                if (m_underrun !== want_rpt.under) begin
                    $error("underrun expected %0d got %0d", want_rpt.under, m_underrun);
                    errors++;
                end
                if (m_dropped !== want_rpt.drop) begin
                    $error("dropped expected %0d got %0d", want_rpt.drop, m_dropped);
                    errors++;
                end
                if (m_fill_level !== want_rpt.fill) begin
                    $error("fill_level expected %0d got %0d", want_rpt.fill, m_fill_level);
                    errors++;
                end
                if (m_below_low !== want_rpt.low) begin
                    $error("below_low expected %0d got %0d", want_rpt.low, m_below_low);
                    errors++;
                end
                if (m_above_high !== want_rpt.high) begin
                    $error("above_high expected %0d got %0d", want_rpt.high, m_above_high);
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, report_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        // reset held low from the start, released at a falling edge
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table under the reset register values
        foreach (dir_table[i])
            send_item(dir_table[i].cmd, dir_table[i].smp, dir_table[i].last,
                      dir_table[i].typed, dir_table[i].rpt);
        quiesce();

        // general random phases across register settings, extremes first
        set_regs(4'd0, 12'd0, 12'd0);
        repeat (80) send_random(MIX_GENERAL);
        quiesce();

        idling = 1'b0;
        set_regs(4'd15, 12'd4095, 12'd4095);
        repeat (80) send_random(MIX_GENERAL);
        quiesce();

        idling = 1'b1;
        set_regs(4'($urandom_range(0, 15)), 12'($urandom_range(0, 48)),
                 12'($urandom_range(0, 96)));
        repeat (80) send_random(MIX_GENERAL);
        quiesce();

        set_regs(4'($urandom_range(0, 15)), 12'($urandom()), 12'($urandom()));
        repeat (80) send_random(MIX_GENERAL);
        quiesce();

        // fill run without idling so the level crosses both marks, then drain and flush
        idling = 1'b0;
        set_regs(4'd0, 12'd60, 12'd120);
        repeat (60) send_random(MIX_FILL);
        repeat (30) send_random(MIX_DRAIN);
        send_item(CMD_FLUSH, 16'sh0000, 1'b0, 1'b0, '0);
        quiesce();

        // back to the reset values with idling on both sides
        idling = 1'b1;
        set_regs(ATTEN_SHIFT_RST, LOW_WATER_RST, HIGH_WATER_RST);
        repeat (60) send_random(MIX_GENERAL);
        quiesce();

        $display("covered %0d command transactions, peak fill %0d", sent, peak_fill);
        $display("pushes losing writes %0d, pops on an empty ring %0d",
                 drop_pushes, underruns);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
